// File: src/tlvp_pkg.sv
`default_nettype none
package tlvp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STAT = 3'd1,
    PH_SEQ  = 3'd2,
    PH_ID   = 3'd3,
    PH_TYPE = 3'd4,
    PH_LENH = 3'd5,
    PH_LENL = 3'd6,
    PH_VAL  = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MALFORMED = 3'd1,
    ST_SHORT     = 3'd2,
    ST_LONG      = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_VALLONG   = 3'd5
  } st_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,  // good header: open a frame
    OP_ABORT = 2'd1,  // bad header: report and go idle
    OP_BYTE  = 2'd2   // payload byte
  } op_t;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] TYPE_MAX_KNOWN = 3'd5;
  localparam logic [2:0] TYPE_UNKNOWN   = 3'd6;

  localparam int MIN_PAYLOAD_LEN = 2;
  localparam int REC_HEAD_LEN    = 4;
  localparam int WORD_BYTES      = 4;

  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int RES_QUEUE_DEPTH = 2;

  typedef struct packed {
    op_t         op;
    st_t         status;
    logic [15:0] frame_length;
    logic [7:0]  data_byte;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    st_t         status;
    logic [3:0]  record_index;
    logic [4:0]  record_count;
    logic [7:0]  point_id;
    logic [2:0]  point_type;
    logic [5:0]  value_length;
    logic [31:0] value_word;
    logic        value_flag;
    logic [7:0]  value_first;
    logic        last_of_item;
  } res_t;

endpackage
`default_nettype wire

// File: src/tlvp_ifs.sv
`default_nettype none
interface tlvp_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] frame_length;
  logic        header_valid;
  logic [7:0]  data_byte;

  modport source (output valid, mode, frame_length, header_valid, data_byte, input ready);
  modport sink   (input valid, mode, frame_length, header_valid, data_byte, output ready);
endinterface

interface tlvp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  status;
  logic [3:0]  record_index;
  logic [4:0]  record_count;
  logic [7:0]  point_id;
  logic [2:0]  point_type;
  logic [5:0]  value_length;
  logic [31:0] value_word;
  logic        value_flag;
  logic [7:0]  value_first;
  logic        last_of_item;

  modport source (output valid, kind, status, record_index, record_count, point_id,
                  point_type, value_length, value_word, value_flag, value_first,
                  last_of_item, input ready);
  modport sink   (input valid, kind, status, record_index, record_count, point_id,
                  point_type, value_length, value_word, value_flag, value_first,
                  last_of_item, output ready);
endinterface
`default_nettype wire

// File: src/tlvp_fifo.sv
`default_nettype none
module tlvp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/tlvp_front.sv
`default_nettype none
module tlvp_front #(
  parameter int MAX_PAYLOAD_LEN = 256
) (
  tlvp_in_if.sink          in_ch,
  output logic             cmd_valid,
  input  wire logic        cmd_ready,
  output tlvp_pkg::cmd_t   cmd
);
  import tlvp_pkg::*;

  assign cmd_valid   = in_ch.valid;
  assign in_ch.ready = cmd_ready;

  // Header checks are settled here so the back end only sees open/abort/byte.
  always_comb begin
    cmd.frame_length = in_ch.frame_length;
    cmd.data_byte    = in_ch.data_byte;
    cmd.status       = ST_OK;
    cmd.op           = OP_BYTE;
    if (!in_ch.mode) begin
      if (!in_ch.header_valid) begin
        cmd.op     = OP_ABORT;
        cmd.status = ST_MALFORMED;
      end else if (in_ch.frame_length < 16'(MIN_PAYLOAD_LEN)) begin
        cmd.op     = OP_ABORT;
        cmd.status = ST_SHORT;
      end else if (in_ch.frame_length > 16'(MAX_PAYLOAD_LEN)) begin
        cmd.op     = OP_ABORT;
        cmd.status = ST_LONG;
      end else begin
        cmd.op = OP_START;
      end
    end
  end
endmodule
`default_nettype wire

// File: src/tlvp_back.sv
`default_nettype none
module tlvp_back #(
  parameter int MAX_PAYLOAD_LEN = 256,
  parameter int MAX_RECORDS     = 16,
  parameter int MAX_VALUE_LEN   = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire tlvp_pkg::cmd_t  cmd,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output tlvp_pkg::res_t       res
);
  import tlvp_pkg::*;

  localparam int PLW = $clog2(MAX_PAYLOAD_LEN + 1);
  localparam int RW  = $clog2(MAX_RECORDS + 1);
  localparam int LW  = $clog2(MAX_VALUE_LEN + 1);
  localparam int SW  = ((PLW > LW) ? PLW : LW) + 1;

  typedef struct packed {
    logic hit;
    st_t  st;
  } bnd_t;

  phase_t         phase, phase_next;
  logic [PLW-1:0] offset, offset_next;
  logic [PLW-1:0] plen, plen_next;
  logic [RW-1:0]  records_done, records_done_next;
  logic [7:0]     cur_id, cur_id_next;
  logic [2:0]     cur_type, cur_type_next;
  logic [7:0]     len_hi, len_hi_next;
  logic [LW-1:0]  cur_len, cur_len_next;
  logic [LW-1:0]  bytes_left, bytes_left_next;
  logic [31:0]    acc, acc_next;
  logic [7:0]     first, first_next;
  logic [2:0]     vcnt, vcnt_next;
  logic           pend, pend_next;
  st_t            pend_st, pend_st_next;

  logic [PLW-1:0] off1;
  logic [15:0]    full_len;
  logic [RW-1:0]  rd_inc;
  logic [7:0]     b;

  function automatic bnd_t boundary(input logic [PLW-1:0] off, input logic [RW-1:0] rd,
                                    input logic [PLW-1:0] len);
    bnd_t r;
    r.hit = 1'b1;
    r.st  = ST_OK;
    if (off >= len) begin
      r.st = ST_OK;
    end else if (rd >= RW'(MAX_RECORDS)) begin
      r.st = ST_OVERFLOW;
    end else if ((PLW + 1)'(off) + (PLW + 1)'(REC_HEAD_LEN) > (PLW + 1)'(len)) begin
      r.st = ST_MALFORMED;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

  function automatic res_t mk_status(input st_t st, input logic [RW-1:0] rd);
    res_t r;
    r              = '0;
    r.kind         = KIND_STATUS;
    r.status       = st;
    r.record_count = 5'(rd);
    r.last_of_item = 1'b1;
    return r;
  endfunction

  assign b        = cmd.data_byte;
  assign off1     = offset + 1'b1;
  assign full_len = {len_hi, b};
  assign rd_inc   = records_done + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      offset       <= '0;
      plen         <= '0;
      records_done <= '0;
      cur_id       <= '0;
      cur_type     <= '0;
      len_hi       <= '0;
      cur_len      <= '0;
      bytes_left   <= '0;
      acc          <= '0;
      first        <= '0;
      vcnt         <= '0;
      pend         <= 1'b0;
      pend_st      <= ST_OK;
    end else begin
      phase        <= phase_next;
      offset       <= offset_next;
      plen         <= plen_next;
      records_done <= records_done_next;
      cur_id       <= cur_id_next;
      cur_type     <= cur_type_next;
      len_hi       <= len_hi_next;
      cur_len      <= cur_len_next;
      bytes_left   <= bytes_left_next;
      acc          <= acc_next;
      first        <= first_next;
      vcnt         <= vcnt_next;
      pend         <= pend_next;
      pend_st      <= pend_st_next;
    end
  end

  always_comb begin
    bnd_t           bnd;
    logic           rec;
    logic [LW-1:0]  left_dec;
    phase_next        = phase;
    offset_next       = offset;
    plen_next         = plen;
    records_done_next = records_done;
    cur_id_next       = cur_id;
    cur_type_next     = cur_type;
    len_hi_next       = len_hi;
    cur_len_next      = cur_len;
    bytes_left_next   = bytes_left;
    acc_next          = acc;
    first_next        = first;
    vcnt_next         = vcnt;
    pend_next         = pend;
    pend_st_next      = pend_st;
    cmd_ready         = 1'b0;
    res_valid         = 1'b0;
    res               = '0;
    rec               = 1'b0;
    bnd               = '0;
    left_dec          = bytes_left - 1'b1;

    if (pend) begin
      // second result of the previous item: frame status after a record
      if (res_ready) begin
        res_valid = 1'b1;
        res       = mk_status(pend_st, records_done);
        pend_next = 1'b0;
      end
    end else if (cmd_valid && res_ready) begin
      cmd_ready = 1'b1;
      case (cmd.op)
        OP_START, OP_ABORT: begin
          offset_next       = '0;
          records_done_next = '0;
          cur_id_next       = '0;
          cur_type_next     = '0;
          len_hi_next       = '0;
          cur_len_next      = '0;
          bytes_left_next   = '0;
          acc_next          = '0;
          first_next        = '0;
          vcnt_next         = '0;
          plen_next         = PLW'(cmd.frame_length);
          if (cmd.op == OP_START) begin
            phase_next = PH_STAT;
          end else begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            res        = mk_status(cmd.status, '0);
          end
        end
        OP_BYTE: begin
          if (phase != PH_IDLE) begin
            offset_next = off1;
          end
          case (phase)
            PH_IDLE: ;
            PH_STAT: phase_next = PH_SEQ;
            PH_SEQ: begin
              bnd = boundary(off1, records_done, plen);
              if (bnd.hit) begin
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                res        = mk_status(bnd.st, records_done);
              end else begin
                phase_next = PH_ID;
              end
            end
            PH_ID: begin
              cur_id_next     = b;
              cur_len_next    = '0;
              bytes_left_next = '0;
              acc_next        = '0;
              first_next      = '0;
              vcnt_next       = '0;
              phase_next      = PH_TYPE;
            end
            PH_TYPE: begin
              cur_type_next = (b <= 8'(TYPE_MAX_KNOWN)) ? b[2:0] : TYPE_UNKNOWN;
              phase_next    = PH_LENH;
            end
            PH_LENH: begin
              len_hi_next = b;
              phase_next  = PH_LENL;
            end
            PH_LENL: begin
              if (full_len > 16'(MAX_VALUE_LEN)) begin
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                res        = mk_status(ST_VALLONG, records_done);
              end else if (SW'(off1) + SW'(full_len) > SW'(plen)) begin
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                res        = mk_status(ST_MALFORMED, records_done);
              end else if (full_len == 16'd0) begin
                cur_len_next = '0;
                rec          = 1'b1;
              end else begin
                cur_len_next    = LW'(full_len);
                bytes_left_next = LW'(full_len);
                phase_next      = PH_VAL;
              end
            end
            PH_VAL: begin
              if (vcnt == '0) begin
                first_next = b;
              end
              if (vcnt < 3'(WORD_BYTES)) begin
                acc_next  = {acc[23:0], b};
                vcnt_next = vcnt + 1'b1;
              end
              bytes_left_next = left_dec;
              if (left_dec == '0) begin
                rec = 1'b1;
              end
            end
            default: ;
          endcase

          if (rec) begin
            // record result from the updated value registers, then check the boundary
            res_valid          = 1'b1;
            res.kind           = KIND_RECORD;
            res.status         = ST_OK;
            res.record_index   = 4'(records_done);
            res.record_count   = 5'(rd_inc);
            res.point_id       = cur_id;
            res.point_type     = cur_type;
            res.value_length   = 6'(cur_len_next);
            res.value_word     = acc_next;
            res.value_flag     = (first_next != 8'd0);
            res.value_first    = first_next;
            records_done_next  = rd_inc;
            bnd = boundary(off1, rd_inc, plen);
            if (bnd.hit) begin
              phase_next       = PH_IDLE;
              res.last_of_item = 1'b0;
              pend_next        = 1'b1;
              pend_st_next     = bnd.st;
            end else begin
              phase_next       = PH_ID;
              res.last_of_item = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/datapoint_tlv_record_parser.sv
`default_nettype none
// Streaming TLV record parser. Send a frame-start beat (mode 0) with the payload
// length and header-valid flag, then one payload beat per byte (status, sequence,
// then records of id, type, 16-bit big-endian length and value). Each completed
// record yields a record result; the frame closes with one status result, after
// which payload bytes are dropped until the next frame start. A frame start in
// the middle of a frame drops the old one silently. The parser takes one beat per
// cycle unless the output queue is full or a second result is pending. A beat that
// both completes a record and ends the frame has two results and holds the parser
// while the second goes out, since one result leaves per cycle on the output port;
// a two-entry queue between the input classifier and the parser and a two-entry
// output queue, both registered, absorb stalls on either side.
module datapoint_tlv_record_parser #(
  parameter int MAX_PAYLOAD_LEN = 256,
  parameter int MAX_RECORDS     = 16,
  parameter int MAX_VALUE_LEN   = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tlvp_in_if.sink    in_ch,
  tlvp_out_if.source out_ch
);
  import tlvp_pkg::*;

  cmd_t fe_cmd;
  cmd_t q_cmd;
  logic fe_valid;
  logic fe_ready;
  logic q_valid;
  logic q_ready;
  res_t be_res;
  res_t out_res;
  logic be_valid;
  logic be_ready;

  tlvp_front #(
    .MAX_PAYLOAD_LEN(MAX_PAYLOAD_LEN)
  ) u_front (
    .in_ch    (in_ch),
    .cmd_valid(fe_valid),
    .cmd_ready(fe_ready),
    .cmd      (fe_cmd)
  );

  tlvp_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_QUEUE_DEPTH)
  ) u_cmd_q (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fe_valid),
    .in_ready (fe_ready),
    .in_data  (fe_cmd),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_data (q_cmd)
  );

  tlvp_back #(
    .MAX_PAYLOAD_LEN(MAX_PAYLOAD_LEN),
    .MAX_RECORDS    (MAX_RECORDS),
    .MAX_VALUE_LEN  (MAX_VALUE_LEN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(q_valid),
    .cmd_ready(q_ready),
    .cmd      (q_cmd),
    .res_valid(be_valid),
    .res_ready(be_ready),
    .res      (be_res)
  );

  tlvp_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_QUEUE_DEPTH)
  ) u_res_q (
    .clk      (clk),
    .rst      (rst),
    .in_valid (be_valid),
    .in_ready (be_ready),
    .in_data  (be_res),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_data (out_res)
  );

  assign out_ch.kind         = out_res.kind;
  assign out_ch.status       = out_res.status;
  assign out_ch.record_index = out_res.record_index;
  assign out_ch.record_count = out_res.record_count;
  assign out_ch.point_id     = out_res.point_id;
  assign out_ch.point_type   = out_res.point_type;
  assign out_ch.value_length = out_res.value_length;
  assign out_ch.value_word   = out_res.value_word;
  assign out_ch.value_flag   = out_res.value_flag;
  assign out_ch.value_first  = out_res.value_first;
  assign out_ch.last_of_item = out_res.last_of_item;
endmodule
`default_nettype wire
